// ===== sv/sub_octave_generator_assert.svh =====
// Assertion macros for the sub-octave generator, clocked on clock and disabled in reset.
`ifndef SUB_OCTAVE_GENERATOR_ASSERT_SVH
`define SUB_OCTAVE_GENERATOR_ASSERT_SVH

// Check that cond in one cycle implies nxt in the following cycle.
`define SOG_ASSERT_NEXT(name, cond, nxt, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (nxt)) \
      else $error(msg);

// Check that cond implies consq in the same cycle.
`define SOG_ASSERT_SAME(name, cond, consq, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (consq)) \
      else $error(msg);

// Check that an expression holds in every cycle out of reset.
`define SOG_ASSERT_ALWAYS(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

`endif

// ===== sv/sog_pkg.sv =====
// Shared types and constants of the sub-octave generator.
package sog_pkg;

   // Register indexes on the csr port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ANALYSIS_COEF = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TONE_COEF     = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DRY_GAIN      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WET_GAIN      = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_THRESHOLD     = 3'd4;

   // Register reset values
   localparam int ANALYSIS_COEF_RESET = 1285;
   localparam int THRESHOLD_RESET     = 8389;

   // Operand selection of the shared multiplier
   localparam logic [1:0] MUL_ANALYSIS = 2'd0;
   localparam logic [1:0] MUL_DRY      = 2'd1;
   localparam logic [1:0] MUL_TONE     = 2'd2;
   localparam logic [1:0] MUL_WET      = 2'd3;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic       load_sample;
      logic       mul_enable;
      logic [1:0] mul_sel;
      logic       update_analysis;
      logic       capture_dry;
      logic       update_tone;
      logic       load_output;
   } sog_cmd_type;

endpackage

// ===== sv/sog_stream_if.sv =====
// Valid/ready stream interfaces for input samples and mixed output samples.
interface sog_req_if #(
   parameter int SAMPLE_WIDTH = 24
) (
   input logic clock
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;

   modport source (input clock, output valid, output sample, input ready);
   modport sink   (input clock, input valid, input sample, output ready);
endinterface

interface sog_rsp_if #(
   parameter int SAMPLE_WIDTH = 24
) (
   input logic clock
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] out_sample;

   modport source (input clock, output valid, output out_sample, input ready);
   modport sink   (input clock, input valid, input out_sample, output ready);
endinterface

// ===== sv/sub_octave_generator.sv =====
// Sub-octave generator: one sample in, one mixed sample out.
// One sample is in work at a time, so a new one is taken only once the last
// result has gone into the output register, which waits while a result is
// still pending there. The single shared multiplier runs four products per
// sample with a level update between them.
// Synchronous reset restores register defaults and clears filter and divider state.
module sub_octave_generator
   import sog_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 24,
   parameter int COEF_WIDTH   = 16,
   localparam int CSR_DATA_WIDTH =
      (COEF_WIDTH > SAMPLE_WIDTH - 1) ? COEF_WIDTH : SAMPLE_WIDTH - 1
) (
   input  logic                       clock,
   input  logic                       reset,
   sog_req_if.sink                    req_stream,
   sog_rsp_if.source                  rsp_stream,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

`include "sub_octave_generator_assert.svh"

   sog_cmd_type cmd;
   logic        req_ready;
   logic        rsp_valid;

   // Sequence each transaction through the datapath
   sog_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_stream.valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_stream.ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   sog_datapath #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_WIDTH     (COEF_WIDTH),
      .CSR_DATA_WIDTH (CSR_DATA_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sample           (req_stream.sample),
      .out_sample       (rsp_stream.out_sample),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   assign req_stream.ready = req_ready;
   assign rsp_stream.valid = rsp_valid;

   // A sample in work blocks the next one
   `SOG_ASSERT_NEXT(a_busy_after_accept, req_stream.valid && req_ready, !req_ready, "accepted a second sample while busy")
   // A new result shows up on the output
   `SOG_ASSERT_NEXT(a_result_presented, cmd.load_output, rsp_valid, "result loaded but not presented")
   // Never overwrite a result still waiting to be taken
   `SOG_ASSERT_SAME(a_no_overwrite, cmd.load_output, !rsp_valid || rsp_stream.ready, "pending result overwritten")
   // Sequencer strobes are exclusive
   `SOG_ASSERT_ALWAYS(a_strobes_exclusive, $onehot0({cmd.load_sample, cmd.update_analysis, cmd.capture_dry, cmd.update_tone, cmd.load_output}), "overlapping datapath strobes")

endmodule

// ===== sv/sog_ctrl.sv =====
// Sequencer that steps one sample through the shared multiplier and output register.
module sog_ctrl
   import sog_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output sog_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ANA  = 3'd1;
   localparam logic [2:0] ST_ANU  = 3'd2;
   localparam logic [2:0] ST_TON  = 3'd3;
   localparam logic [2:0] ST_TNU  = 3'd4;
   localparam logic [2:0] ST_WET  = 3'd5;
   localparam logic [2:0] ST_MIX  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Decode the step into datapath commands
   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready       = 1'b1;
            cmd.load_sample = req_valid;
            if (req_valid) state_in = ST_ANA;
         end
         ST_ANA: begin
            cmd.mul_enable = 1'b1;
            cmd.mul_sel    = MUL_ANALYSIS;
            state_in       = ST_ANU;
         end
         ST_ANU: begin
            cmd.update_analysis = 1'b1;
            cmd.mul_enable      = 1'b1;
            cmd.mul_sel         = MUL_DRY;
            state_in            = ST_TON;
         end
         ST_TON: begin
            cmd.capture_dry = 1'b1;
            cmd.mul_enable  = 1'b1;
            cmd.mul_sel     = MUL_TONE;
            state_in        = ST_TNU;
         end
         ST_TNU: begin
            cmd.update_tone = 1'b1;
            state_in        = ST_WET;
         end
         ST_WET: begin
            cmd.mul_enable = 1'b1;
            cmd.mul_sel    = MUL_WET;
            state_in       = ST_MIX;
         end
         ST_MIX: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_output = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Set on a new result, drop once the transaction completes
   assign rsp_valid_in = cmd.load_output | (rsp_valid_ff & ~rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/sog_datapath.sv =====
// Filters, crossing detector, shared multiplier, mixer and register file.
module sog_datapath
   import sog_pkg::*;
#(
   parameter int SAMPLE_WIDTH   = 24,
   parameter int COEF_WIDTH     = 16,
   parameter int CSR_DATA_WIDTH = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  sog_cmd_type                    cmd,
   input  logic signed [SAMPLE_WIDTH-1:0] sample,
   output logic signed [SAMPLE_WIDTH-1:0] out_sample,
   input  logic                           csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]      csr_write_data
);

   localparam int LW = SAMPLE_WIDTH + 1;   // filter level
   localparam int DW = SAMPLE_WIDTH + 2;   // multiplier sample operand
   localparam int BW = COEF_WIDTH + 1;     // multiplier coefficient operand
   localparam int PW = DW + BW;            // product
   localparam int MW = PW + 1;             // mix sum
   localparam int GF = COEF_WIDTH - 2;     // gain fraction bits

   localparam logic signed [PW-1:0] LEVEL_HALF =
      {{(PW-COEF_WIDTH){1'b0}}, 1'b1, {(COEF_WIDTH-1){1'b0}}};
   localparam logic signed [MW-1:0] MIX_HALF = {{(MW-GF){1'b0}}, 1'b1, {(GF-1){1'b0}}};
   localparam logic signed [MW-1:0] MIX_MAX =
      {{(MW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [MW-1:0] MIX_MIN =
      {{(MW-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

   logic [COEF_WIDTH-1:0]     acoef_ff, tcoef_ff, dry_ff, wet_ff;
   logic [SAMPLE_WIDTH-2:0]   thr_ff;
   logic signed [SAMPLE_WIDTH-1:0] x_ff;
   logic signed [LW-1:0]      ana_ff, ana_in, tone_ff, tone_in;
   logic                      pol_ff, pol_in, cnt_ff, cnt_in;
   logic signed [PW-1:0]      prod_ff, acc_ff;
   logic signed [SAMPLE_WIDTH-1:0] out_ff, out_in;

   logic signed [DW-1:0]      op_a;
   logic signed [BW-1:0]      op_b;
   logic signed [PW-1:0]      product, level_step;
   logic signed [LW-1:0]      thr_ext, mag, oct;
   logic                      rise;
   logic signed [MW-1:0]      mix_sum, mix_round;

   // Select the multiplier operands for the current step
   assign mag = x_ff[SAMPLE_WIDTH-1] ? -LW'(x_ff) : LW'(x_ff);
   assign oct = pol_ff ? -mag : mag;

   always_comb begin
      case (cmd.mul_sel)
         MUL_ANALYSIS: begin
            op_a = DW'(x_ff) - DW'(ana_ff);
            op_b = signed'({1'b0, acoef_ff});
         end
         MUL_DRY: begin
            op_a = DW'(x_ff);
            op_b = signed'({1'b0, dry_ff});
         end
         MUL_TONE: begin
            op_a = DW'(oct) - DW'(tone_ff);
            op_b = signed'({1'b0, tcoef_ff});
         end
         default: begin
            op_a = DW'(tone_ff);
            op_b = signed'({1'b0, wet_ff});
         end
      endcase
   end

   assign product = op_a * op_b;

   // Round the filter step, ties toward plus infinity
   assign level_step = (prod_ff + LEVEL_HALF) >>> COEF_WIDTH;
   assign ana_in     = ana_ff + level_step[LW-1:0];
   assign tone_in    = tone_ff + level_step[LW-1:0];

   // Detect a rising crossing of the threshold
   assign thr_ext = signed'({2'b00, thr_ff});
   assign rise    = (ana_ff <= thr_ext) && (ana_in > thr_ext);
   assign cnt_in  = cnt_ff ^ rise;
   assign pol_in  = pol_ff ^ (rise & cnt_ff);

   // Mix, round and saturate
   assign mix_sum   = MW'(acc_ff) + MW'(prod_ff);
   assign mix_round = (mix_sum + MIX_HALF) >>> GF;

   always_comb begin
      if (mix_round > MIX_MAX) begin
         out_in = MIX_MAX[SAMPLE_WIDTH-1:0];
      end else if (mix_round < MIX_MIN) begin
         out_in = MIX_MIN[SAMPLE_WIDTH-1:0];
      end else begin
         out_in = mix_round[SAMPLE_WIDTH-1:0];
      end
   end

   assign out_sample = out_ff;

   // Filter and divider state
   always_ff @(posedge clock) begin
      if (reset) begin
         ana_ff  <= '0;
         tone_ff <= '0;
         pol_ff  <= 1'b0;
         cnt_ff  <= 1'b0;
      end else begin
         if (cmd.update_analysis) begin
            ana_ff <= ana_in;
            pol_ff <= pol_in;
            cnt_ff <= cnt_in;
         end
         if (cmd.update_tone) tone_ff <= tone_in;
      end
   end

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         acoef_ff <= COEF_WIDTH'(ANALYSIS_COEF_RESET);
         tcoef_ff <= '0;
         dry_ff   <= '0;
         wet_ff   <= '0;
         thr_ff   <= (SAMPLE_WIDTH-1)'(THRESHOLD_RESET);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ANALYSIS_COEF: acoef_ff <= csr_write_data[COEF_WIDTH-1:0];
            CSR_TONE_COEF:     tcoef_ff <= csr_write_data[COEF_WIDTH-1:0];
            CSR_DRY_GAIN:      dry_ff   <= csr_write_data[COEF_WIDTH-1:0];
            CSR_WET_GAIN:      wet_ff   <= csr_write_data[COEF_WIDTH-1:0];
            CSR_THRESHOLD:     thr_ff   <= csr_write_data[SAMPLE_WIDTH-2:0];
            default: begin
            end
         endcase
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_sample) x_ff <= sample;
      if (cmd.mul_enable)  prod_ff <= product;
      if (cmd.capture_dry) acc_ff <= prod_ff;
      if (cmd.load_output) out_ff <= out_in;
   end

endmodule

// ===== tb/sv/sog_checker.sv =====
// Scoreboard for the sub-octave generator: predicts each mixed sample and compares it.
module sog_checker
   import sog_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 24,
   parameter int COEF_WIDTH   = 16,
   localparam int CSR_DATA_WIDTH =
      (COEF_WIDTH > SAMPLE_WIDTH - 1) ? COEF_WIDTH : SAMPLE_WIDTH - 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] rsp_out_sample,
   input  logic                           csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]      csr_write_data,
   output int                             mismatch_count,
   output int                             results_owed
);

   localparam int     GAIN_FRAC  = COEF_WIDTH - 2;
   localparam longint SAMPLE_TOP = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
   localparam longint SAMPLE_BOT = -SAMPLE_TOP - 1;

   // Shadow copy of the configuration registers
   logic [COEF_WIDTH-1:0]   analysis_alpha;
   logic [COEF_WIDTH-1:0]   tone_alpha;
   logic [COEF_WIDTH-1:0]   dry_gain;
   logic [COEF_WIDTH-1:0]   wet_gain;
   logic [SAMPLE_WIDTH-2:0] crossing_level;

   // Filter and divider state
   longint analysis_level;
   longint tone_level;
   longint previous_analysis;
   logic   polarity_negative;
   logic   crossing_count;

   logic signed [SAMPLE_WIDTH-1:0] pending_mixes[$];
   logic signed [SAMPLE_WIDTH-1:0] oldest_mix;
   int                             mismatches = 0;

   // Divide by a power of two, rounding half toward plus infinity
   function automatic longint round_shift(input longint value, input int shift);
      return (value + (longint'(1) << (shift - 1))) >>> shift;
   endfunction

   function automatic longint one_pole(input longint level, input longint target,
                                       input logic [COEF_WIDTH-1:0] alpha);
      return level + round_shift((target - level) * longint'(alpha), COEF_WIDTH);
   endfunction

   // Advance the filters and the divider by one sample and return the mix
   function automatic logic signed [SAMPLE_WIDTH-1:0] mix_next_sample(
      input logic signed [SAMPLE_WIDTH-1:0] sample);
      longint x;
      longint magnitude;
      longint octave;
      longint mix;
      x = sample;
      analysis_level = one_pole(analysis_level, x, analysis_alpha);

      // Toggle the two-step counter on a rising crossing; flip polarity on wrap
      if (previous_analysis <= longint'(crossing_level) &&
          analysis_level > longint'(crossing_level)) begin
         if (crossing_count) begin
            crossing_count    = 1'b0;
            polarity_negative = !polarity_negative;
         end else begin
            crossing_count = 1'b1;
         end
      end
      previous_analysis = analysis_level;

      magnitude  = (x < 0) ? -x : x;
      octave     = polarity_negative ? -magnitude : magnitude;
      tone_level = one_pole(tone_level, octave, tone_alpha);

      mix = round_shift(x * longint'(dry_gain) + tone_level * longint'(wet_gain), GAIN_FRAC);
      if (mix > SAMPLE_TOP) mix = SAMPLE_TOP;
      if (mix < SAMPLE_BOT) mix = SAMPLE_BOT;
      return mix[SAMPLE_WIDTH-1:0];
   endfunction

   // Track register writes, predict on input transactions, compare on output ones
   always @(posedge clock) begin
      if (reset) begin
         analysis_alpha    = COEF_WIDTH'(ANALYSIS_COEF_RESET);
         tone_alpha        = '0;
         dry_gain          = '0;
         wet_gain          = '0;
         crossing_level    = (SAMPLE_WIDTH - 1)'(THRESHOLD_RESET);
         analysis_level    = 0;
         tone_level        = 0;
         previous_analysis = 0;
         polarity_negative = 1'b0;
         crossing_count    = 1'b0;
         pending_mixes.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_ANALYSIS_COEF: analysis_alpha = csr_write_data[COEF_WIDTH-1:0];
               CSR_TONE_COEF:     tone_alpha     = csr_write_data[COEF_WIDTH-1:0];
               CSR_DRY_GAIN:      dry_gain       = csr_write_data[COEF_WIDTH-1:0];
               CSR_WET_GAIN:      wet_gain       = csr_write_data[COEF_WIDTH-1:0];
               CSR_THRESHOLD:     crossing_level = csr_write_data[SAMPLE_WIDTH-2:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            pending_mixes.push_back(mix_next_sample(req_sample));
         if (rsp_valid && rsp_ready) begin
            if (pending_mixes.size() == 0) begin
               $error("out_sample: transaction with nothing expected, actual %0d",
                      rsp_out_sample);
               mismatches++;
            end else begin
               oldest_mix = pending_mixes.pop_front();
               if (rsp_out_sample !== oldest_mix) begin
                  $error("out_sample: expected %0d, actual %0d", oldest_mix, rsp_out_sample);
                  mismatches++;
               end
            end
         end
      end
      mismatch_count <= mismatches;
      results_owed   <= pending_mixes.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the sub-octave generator testbench: clock, reset, stimulus and verdict.
module testbench;
   import sog_pkg::*;

   localparam int SAMPLE_WIDTH   = 24;
   localparam int COEF_WIDTH     = 16;
   localparam int CSR_DATA_WIDTH =
      (COEF_WIDTH > SAMPLE_WIDTH - 1) ? COEF_WIDTH : SAMPLE_WIDTH - 1;
   localparam int IDLE_LIMIT     = 2000;
   localparam int LONG_HOLD      = 300;
   localparam int SETTLE_CYCLES  = 4;
   localparam int TAIL_CYCLES    = 12;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 190;

   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX =
      SAMPLE_WIDTH'(2 ** (SAMPLE_WIDTH - 1) - 1);
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN =
      SAMPLE_WIDTH'(-(2 ** (SAMPLE_WIDTH - 1)));
   localparam logic [SAMPLE_WIDTH-2:0]        LEVEL_MAX  = '1;
   localparam logic [CSR_INDEX_WIDTH-1:0]     CSR_FIRST_UNUSED =
      CSR_THRESHOLD + CSR_INDEX_WIDTH'(1);

   logic                       clock;
   logic                       reset;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   int mismatch_count;
   int results_owed;
   int quiet_cycles = 0;

   // Idling modes, set per phase by the sender
   bit sender_steady   = 1'b0;
   bit receiver_steady = 1'b0;
   bit hold_off_request = 1'b0;

   sog_req_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) req_if (.clock(clock));
   sog_rsp_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) rsp_if (.clock(clock));

   sub_octave_generator #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .COEF_WIDTH  (COEF_WIDTH)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_stream      (req_if),
      .rsp_stream      (rsp_if),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   sog_checker #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .COEF_WIDTH  (COEF_WIDTH)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_if.valid),
      .req_ready       (req_if.ready),
      .req_sample      (req_if.sample),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_out_sample  (rsp_if.out_sample),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .mismatch_count  (mismatch_count),
      .results_owed    (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Write all five registers plus one unused index, with junk in the high bits
   task automatic program_settings(input logic [COEF_WIDTH-1:0] analysis_alpha,
                                   input logic [COEF_WIDTH-1:0] tone_alpha,
                                   input logic [COEF_WIDTH-1:0] dry_gain,
                                   input logic [COEF_WIDTH-1:0] wet_gain,
                                   input logic [SAMPLE_WIDTH-2:0] crossing_level);
      logic [CSR_INDEX_WIDTH-1:0] index_list[6];
      logic [CSR_DATA_WIDTH-1:0]  data_list[6];
      index_list = '{CSR_ANALYSIS_COEF, CSR_TONE_COEF, CSR_DRY_GAIN, CSR_WET_GAIN,
                     CSR_THRESHOLD,
                     CSR_FIRST_UNUSED + CSR_INDEX_WIDTH'($urandom_range(0, 2))};
      foreach (data_list[i]) data_list[i] = CSR_DATA_WIDTH'($urandom);
      data_list[0][COEF_WIDTH-1:0] = analysis_alpha;
      data_list[1][COEF_WIDTH-1:0] = tone_alpha;
      data_list[2][COEF_WIDTH-1:0] = dry_gain;
      data_list[3][COEF_WIDTH-1:0] = wet_gain;
      data_list[4][SAMPLE_WIDTH-2:0] = crossing_level;
      for (int i = 0; i < 6; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= index_list[i];
         csr_write_data   <= data_list[i];
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   // Offer one sample after a random gap and hold it until accepted
   task automatic offer_sample(input logic signed [SAMPLE_WIDTH-1:0] sample);
      int gap;
      gap = sender_steady ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.sample <= sample;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
   endtask

   // Drop valid and wait until every predicted result has been drained
   task automatic settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [COEF_WIDTH-1:0] draw_coefficient();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return COEF_WIDTH'($urandom_range(1, 2000));
         default: return COEF_WIDTH'($urandom);
      endcase
   endfunction

   function automatic logic [SAMPLE_WIDTH-2:0] draw_threshold();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return LEVEL_MAX;
         default: return (SAMPLE_WIDTH - 1)'($urandom_range(0, 1 << 21));
      endcase
   endfunction

   // Noisy square wave, with occasional raw words and full-scale spikes
   function automatic logic signed [SAMPLE_WIDTH-1:0] shape_sample(input int index,
                                                                  input int half_period,
                                                                  input int amplitude,
                                                                  input int noise);
      longint value;
      case ($urandom_range(0, 15))
         0: return SAMPLE_WIDTH'($urandom);
         1: return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
         default: ;
      endcase
      value = ((index / half_period) % 2 == 0) ? amplitude : -amplitude;
      value = value + longint'($urandom_range(0, 2 * noise)) - noise;
      if (value > SAMPLE_MAX) value = SAMPLE_MAX;
      if (value < SAMPLE_MIN) value = SAMPLE_MIN;
      return value[SAMPLE_WIDTH-1:0];
   endfunction

   // Result sink: random stalls, one long hold-off on request
   initial begin
      int gap;
      bit held;
      held = 1'b0;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off_request && !held) begin
            held = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            gap = receiver_steady ? 0 : $urandom_range(0, 10);
            if (gap != 0) begin
               rsp_if.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
      end
   end

   // Abort when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == IDLE_LIMIT) begin
         $error("no transaction for %0d cycles", IDLE_LIMIT);
         $display("testbench: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus and verdict
   initial begin
      logic signed [SAMPLE_WIDTH-1:0] corner_samples[15];
      int half_period;
      int amplitude;
      int noise;
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.sample    <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_ANALYSIS_COEF;
      csr_write_data   <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Register defaults: zero gains give a silent output
      offer_sample(SAMPLE_MAX);
      offer_sample(SAMPLE_MIN);
      offer_sample('0);
      offer_sample(SAMPLE_WIDTH'(5000));
      settle();

      // Full-scale coefficients and gains: crossings at zero, saturation both ways
      program_settings('1, '1, '1, '1, '0);
      corner_samples = '{SAMPLE_WIDTH'(0), SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN,
                         SAMPLE_MIN, SAMPLE_MIN, SAMPLE_WIDTH'(-1), SAMPLE_WIDTH'(1),
                         SAMPLE_WIDTH'(-1), SAMPLE_MAX, 24'h555555, 24'hAAAAAA,
                         SAMPLE_WIDTH'(0), SAMPLE_MAX};
      foreach (corner_samples[i]) offer_sample(corner_samples[i]);
      settle();

      // Frozen filters, unity dry gain, unreachable threshold: output follows input
      program_settings('0, '0, COEF_WIDTH'(1 << (COEF_WIDTH - 2)), '0, LEVEL_MAX);
      offer_sample(SAMPLE_MAX);
      offer_sample(SAMPLE_MIN);
      offer_sample(24'h123456);
      settle();

      // Random phases: each with its own settings, waveform and idling mode
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         program_settings(draw_coefficient(), draw_coefficient(), draw_coefficient(),
                          draw_coefficient(), draw_threshold());
         sender_steady   = (phase % 3 == 1);
         receiver_steady = (phase % 4 == 2);
         if (phase == 2) hold_off_request = 1'b1;
         half_period = $urandom_range(1, 24);
         amplitude   = $urandom_range(0, SAMPLE_MAX);
         noise       = $urandom_range(0, 1) ? 0 : $urandom_range(1, 1 << $urandom_range(1, 20));
         for (int i = 0; i < PHASE_ITEMS; i++)
            offer_sample(shape_sample(i, half_period, amplitude, noise));
         settle();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && results_owed == 0) begin
         $display("testbench: clean");
      end else begin
         if (results_owed != 0) $error("out_sample: %0d results never arrived", results_owed);
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
